// File: hw/rtl/altimeter_moving_average_conditioner_top_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ALTIMETER_MOVING_AVERAGE_CONDITIONER_TOP_MACROS_SVH
`define ALTIMETER_MOVING_AVERAGE_CONDITIONER_TOP_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define AMAC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define AMAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/amac_pkg.sv
package amac_pkg;

  localparam int WINDOW_LEN = 20;
  localparam int WIN_CLOG   = $clog2(WINDOW_LEN);
  localparam int WIN_IDX_W  = (WINDOW_LEN > 1) ? WIN_CLOG : 1;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  localparam int LEVEL_W     = 20;
  localparam int TEMP_W      = 12;
  localparam int OFFSET_W    = 21;
  localparam int LEVEL_OUT_W = 25;
  localparam int TEMP_OUT_W  = 16;

  // Window sums: bounded by WINDOW_LEN times the largest entry magnitude
  localparam int LSUM_W = WIN_CLOG + LEVEL_W;
  localparam int TSUM_W = WIN_CLOG + TEMP_W;

  // Biased dividends: the bias is WINDOW_LEN * 2^k, which lifts the scaled sum
  // into a non-negative range so the floor quotient is an unsigned divide minus 2^k
  localparam int LBIAS_EXP = 23;
  localparam int TBIAS_EXP = 15;
  localparam longint unsigned LBIAS = longint'(WINDOW_LEN) << LBIAS_EXP;
  localparam longint unsigned TBIAS = longint'(WINDOW_LEN) << TBIAS_EXP;
  localparam int LU_W = WIN_CLOG + LBIAS_EXP + 1;
  localparam int TU_W = WIN_CLOG + TBIAS_EXP + 1;

  // Reciprocal multiply: q = (u * M) >> S, with M = ceil(2^S / WINDOW_LEN)
  localparam int LDIV_SHIFT = LU_W + WIN_CLOG;
  localparam int TDIV_SHIFT = TU_W + WIN_CLOG;
  localparam int LMUL_W     = LU_W + 1;
  localparam int TMUL_W     = TU_W + 1;
  localparam longint unsigned LDIV_MUL =
    ((64'd1 << LDIV_SHIFT) + longint'(WINDOW_LEN) - 64'd1) / longint'(WINDOW_LEN);
  localparam longint unsigned TDIV_MUL =
    ((64'd1 << TDIV_SHIFT) + longint'(WINDOW_LEN) - 64'd1) / longint'(WINDOW_LEN);
  localparam int LPROD_W = LU_W + LMUL_W;
  localparam int TPROD_W = TU_W + TMUL_W;
  localparam int LQ_W    = LBIAS_EXP + 2;
  localparam int TQ_W    = TBIAS_EXP + 2;

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic MODE_ALTITUDE = 1'b0;
  localparam logic MODE_PRESSURE = 1'b1;

  typedef struct packed {
    logic signed [TEMP_OUT_W-1:0]  temp_value;
    logic signed [LEVEL_OUT_W-1:0] level_value;
  } result_t;

endpackage

// File: hw/rtl/altimeter_moving_average_conditioner_top.sv
// Barometer reading conditioner: 20-entry boxcar mean of level and temperature.
//
// in_*  : one five-byte reading per transaction, bytes packed lowest first.
// out_* : one result per reading, level mean (altitude 1/256 m with start
//         offset, or pascals) and temperature mean in 1/256 degC.
// cfg_* : measure_mode; the user must write it only while no transaction is
//         in flight, as the block does not enforce this.
// A result passes the input, window, scale and product registers, then the
// queue. Throughput: one reading per cycle while in_tready is high; the
// running sums are updated in a single pass and the divide by the window
// length is a registered reciprocal multiply, so no stage iterates.
//
// Reset clears both windows, the sums, the write index and the start offset.
// Results drain into an 8-entry queue; in_tready falls once 8 transactions
// are in flight or queued, so a stalled receiver blocks input once the queue
// and the pipeline together hold 8 readings. Nothing is ever dropped.
`include "altimeter_moving_average_conditioner_top_macros.svh"

module altimeter_moving_average_conditioner_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // level_msb, level_csb, level_lsb, temp_msb, temp_lsb
  input  logic [amac_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // level_value[24:0], temp_value[40:25], zero pad
  output logic [amac_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import amac_pkg::*;

  localparam logic [LMUL_W-1:0] LMUL = LMUL_W'(LDIV_MUL);
  localparam logic [TMUL_W-1:0] TMUL = TMUL_W'(TDIV_MUL);
  localparam logic signed [LQ_W+1:0] LQ_OFS  = (LQ_W+2)'(64'd1 << LBIAS_EXP);
  localparam logic signed [TQ_W:0]   TQ_OFS  = (TQ_W+1)'(64'd1 << TBIAS_EXP);
  localparam logic signed [LQ_W+1:0] LVL_MAX = (LQ_W+2)'((64'd1 << (LEVEL_OUT_W-1)) - 1);
  localparam logic signed [LQ_W+1:0] LVL_MIN = -LVL_MAX - 1;
  localparam logic signed [TQ_W:0]   TMP_MAX = (TQ_W+1)'((64'd1 << (TEMP_OUT_W-1)) - 1);
  localparam logic signed [TQ_W:0]   TMP_MIN = -TMP_MAX - 1;

  logic in_acc, out_acc;
  assign in_acc  = in_tvalid & in_tready;

  // Configuration
  logic mode_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ALTITUDE;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // Stage 0: input register
  logic                  v0_r;
  logic [IN_TDATA_W-1:0] raw_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= in_acc;
    end
    if (in_acc) begin
      raw_r <= in_tdata;
    end
  end

  // Stage 1: decode, window and running sum update
  logic signed [LEVEL_W-1:0]  alt_val, lvl_val;
  logic signed [TEMP_W-1:0]   tmp_val;
  logic signed [LEVEL_W-1:0]  lwin_r [WINDOW_LEN];
  logic signed [TEMP_W-1:0]   twin_r [WINDOW_LEN];
  logic [WIN_IDX_W-1:0]       idx_r, idx_nxt;
  logic signed [LSUM_W-1:0]   lsum_r, lsum_nxt;
  logic signed [TSUM_W-1:0]   tsum_r, tsum_nxt;
  logic                       offset_taken_r;
  logic signed [OFFSET_W-1:0] offset_r;
  logic                       v1_r;

  always_comb begin
    alt_val = $signed({raw_r[7:0], raw_r[15:8], raw_r[23:20]});
    lvl_val = (mode_r == MODE_PRESSURE) ?
              $signed({2'b00, raw_r[7:0], raw_r[15:8], raw_r[23:22]}) : alt_val;
    tmp_val = $signed({raw_r[31:24], raw_r[39:36]});
    lsum_nxt = lsum_r + LSUM_W'(lvl_val) - LSUM_W'(lwin_r[idx_r]);
    tsum_nxt = tsum_r + TSUM_W'(tmp_val) - TSUM_W'(twin_r[idx_r]);
    idx_nxt = (idx_r == WIN_IDX_W'(WINDOW_LEN - 1)) ? '0 : idx_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r           <= 1'b0;
      idx_r          <= '0;
      lsum_r         <= '0;
      tsum_r         <= '0;
      offset_taken_r <= 1'b0;
      offset_r       <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        lwin_r[i] <= '0;
        twin_r[i] <= '0;
      end
    end else begin
      v1_r <= v0_r;
      if (v0_r) begin
        lwin_r[idx_r] <= lvl_val;
        twin_r[idx_r] <= tmp_val;
        idx_r         <= idx_nxt;
        lsum_r        <= lsum_nxt;
        tsum_r        <= tsum_nxt;
        // Capture the start offset on the first altitude reading only
        if (mode_r == MODE_ALTITUDE && !offset_taken_r) begin
          offset_taken_r <= 1'b1;
          offset_r       <= -OFFSET_W'(alt_val);
        end
      end
    end
  end

  // Stage 2: scale and bias the sums for an unsigned divide
  logic signed [LU_W:0] ln_ext, ln_scaled;
  logic signed [TU_W:0] tn_scaled;
  logic [LU_W-1:0]      lu_r;
  logic [TU_W-1:0]      tu_r;
  logic                 v2_r;

  always_comb begin
    ln_ext    = (LU_W+1)'(lsum_r);
    ln_scaled = (mode_r == MODE_PRESSURE) ? ln_ext : (ln_ext <<< 4);
    tn_scaled = (TU_W+1)'(tsum_r) <<< 4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    lu_r <= LU_W'(ln_scaled + $signed((LU_W+1)'(LBIAS)));
    tu_r <= TU_W'(tn_scaled + $signed((TU_W+1)'(TBIAS)));
  end

  // Stage 3: reciprocal multiply
  logic [LPROD_W-1:0] lprod_r;
  logic [TPROD_W-1:0] tprod_r;
  logic               v3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    lprod_r <= LPROD_W'(lu_r) * LPROD_W'(LMUL);
    tprod_r <= TPROD_W'(tu_r) * TPROD_W'(TMUL);
  end

  // Stage 4: remove the bias, add the start offset, saturate
  logic signed [LQ_W+1:0] lvl_full, ofs_term;
  logic signed [TQ_W:0]   tmp_full;
  result_t                res;

  always_comb begin
    ofs_term = (mode_r == MODE_ALTITUDE) ? ((LQ_W+2)'(offset_r) <<< 4) : '0;
    lvl_full = $signed({2'b00, lprod_r[LDIV_SHIFT +: LQ_W]}) - LQ_OFS + ofs_term;
    tmp_full = $signed({1'b0, tprod_r[TDIV_SHIFT +: TQ_W]}) - TQ_OFS;
    priority if (lvl_full > LVL_MAX) begin
      res.level_value = LVL_MAX[LEVEL_OUT_W-1:0];
    end else if (lvl_full < LVL_MIN) begin
      res.level_value = LVL_MIN[LEVEL_OUT_W-1:0];
    end else begin
      res.level_value = lvl_full[LEVEL_OUT_W-1:0];
    end
    priority if (tmp_full > TMP_MAX) begin
      res.temp_value = TMP_MAX[TEMP_OUT_W-1:0];
    end else if (tmp_full < TMP_MIN) begin
      res.temp_value = TMP_MIN[TEMP_OUT_W-1:0];
    end else begin
      res.temp_value = tmp_full[TEMP_OUT_W-1:0];
    end
  end

  // Result queue and credit count
  result_t               fifo_r [FIFO_DEPTH];
  logic [FIFO_AW:0]      wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] credit_r;

  assign out_tvalid = (wr_ptr_r != rd_ptr_r);
  assign out_acc    = out_tvalid & out_tready;
  assign out_tdata  = OUT_TDATA_W'(fifo_r[rd_ptr_r[FIFO_AW-1:0]]);
  assign in_tready  = (credit_r < FIFO_CNT_W'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      credit_r <= '0;
    end else begin
      if (v3_r) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      credit_r <= credit_r + FIFO_CNT_W'(in_acc) - FIFO_CNT_W'(out_acc);
    end
    if (v3_r) begin
      fifo_r[wr_ptr_r[FIFO_AW-1:0]] <= res;
    end
  end

  `AMAC_ASSERT_IMPL(a_credit_bound, clk, rst_n, 1'b1, credit_r <= FIFO_CNT_W'(FIFO_DEPTH), "credit count exceeds queue depth")
  `AMAC_ASSERT_IMPL(a_queue_within_credit, clk, rst_n, 1'b1, (FIFO_CNT_W+1)'((FIFO_AW+1)'(wr_ptr_r - rd_ptr_r)) <= (FIFO_CNT_W+1)'(credit_r), "queue holds more results than transactions in flight")
  `AMAC_ASSERT_IMPL(a_index_range, clk, rst_n, 1'b1, {1'b0, idx_r} < (WIN_IDX_W+1)'(WINDOW_LEN), "window index out of range")
  `AMAC_ASSERT_NEXT(a_offset_sticky, clk, rst_n, offset_taken_r, offset_taken_r && $stable(offset_r), "start offset changed after capture")
  `AMAC_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_acc, v0_r, "accepted transaction not held in the input stage")

endmodule

// File: sim/amac_mean_checker.sv
`timescale 1ns / 1ps

module amac_mean_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_wdata,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // level_msb, level_csb, level_lsb, temp_msb, temp_lsb
  input  logic [amac_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // level_value[24:0], temp_value[40:25], zero pad
  input  logic [amac_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                               outstanding,
  output int                               fail_count
);
  import amac_pkg::*;

  localparam int RESULT_W = LEVEL_OUT_W + TEMP_OUT_W;

  logic                      mode;
  logic signed [LEVEL_W-1:0] level_hist [WINDOW_LEN];
  logic signed [TEMP_W-1:0]  temp_hist  [WINDOW_LEN];
  int unsigned               slot;
  longint                    level_total;
  longint                    temp_total;
  bit                        offset_held;
  longint                    start_offset;
  result_t                   expected_means [$];
  int                        errs = 0;

  // Quotient rounded toward minus infinity.
  function automatic longint floor_by_window(longint n);
    longint q;
    q = n / WINDOW_LEN;
    if (q * WINDOW_LEN > n) q = q - 1;
    return q;
  endfunction

  function automatic longint saturate(longint v, int w);
    longint lo;
    longint hi;
    lo = -(longint'(1) <<< (w - 1));
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic predict_means(input logic [IN_TDATA_W-1:0] d);
    logic [7:0]                lv_msb;
    logic [7:0]                lv_csb;
    logic [7:0]                lv_lsb;
    logic [7:0]                t_msb;
    logic [7:0]                t_lsb;
    logic signed [LEVEL_W-1:0] level;
    logic signed [TEMP_W-1:0]  temp;
    longint                    lvl;
    longint                    tmp;
    result_t                   r;
    lv_msb = d[7:0];
    lv_csb = d[15:8];
    lv_lsb = d[23:16];
    t_msb  = d[31:24];
    t_lsb  = d[39:32];
    if (mode == MODE_ALTITUDE) begin
      // signed metres in the top 16 bits, sixteenths below
      level = {lv_msb, lv_csb, lv_lsb[7:4]};
      if (!offset_held) begin
        offset_held  = 1'b1;
        start_offset = -longint'(level);
      end
    end else begin
      // drop the quarter and half pascal bits
      level = {2'b00, lv_msb, lv_csb, lv_lsb[7:6]};
    end
    temp = {t_msb, t_lsb[7:4]};

    level_total = level_total + longint'(level) - longint'(level_hist[slot]);
    temp_total  = temp_total + longint'(temp) - longint'(temp_hist[slot]);
    level_hist[slot] = level;
    temp_hist[slot]  = temp;
    slot = (slot + 1 == WINDOW_LEN) ? 0 : slot + 1;

    if (mode == MODE_ALTITUDE)
      lvl = floor_by_window(level_total * 16) + start_offset * 16;
    else
      lvl = floor_by_window(level_total);
    lvl = saturate(lvl, LEVEL_OUT_W);
    tmp = saturate(floor_by_window(temp_total * 16), TEMP_OUT_W);

    r.level_value = lvl[LEVEL_OUT_W-1:0];
    r.temp_value  = tmp[TEMP_OUT_W-1:0];
    expected_means.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    result_t seen;
    result_t want;
    if (!rst_n) begin
      mode         = MODE_ALTITUDE;
      slot         = 0;
      level_total  = 0;
      temp_total   = 0;
      offset_held  = 1'b0;
      start_offset = 0;
      foreach (level_hist[i]) begin
        level_hist[i] = '0;
        temp_hist[i]  = '0;
      end
      expected_means.delete();
    end else begin
      if (cfg_we) mode = cfg_wdata;
      if (in_tvalid && in_tready) predict_means(in_tdata);
      if (out_tvalid && out_tready) begin
        seen = out_tdata[RESULT_W-1:0];
        if (expected_means.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual level %0d temp %0d",
                   $time, $signed(seen.level_value), $signed(seen.temp_value));
          errs++;
        end else begin
          want = expected_means.pop_front();
          if (seen.level_value !== want.level_value) begin
            $display("%0t: level_value expected %0d, actual %0d", $time,
                     $signed(want.level_value), $signed(seen.level_value));
            errs++;
          end
          if (seen.temp_value !== want.temp_value) begin
            $display("%0t: temp_value expected %0d, actual %0d", $time,
                     $signed(want.temp_value), $signed(seen.temp_value));
            errs++;
          end
        end
      end
    end
    outstanding <= expected_means.size();
    fail_count  <= errs;
  end

endmodule

// File: sim/altimeter_moving_average_conditioner_top_tb.sv
`timescale 1ns / 1ps

module altimeter_moving_average_conditioner_top_tb;
  import amac_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 75;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic                   cfg_wdata  = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tready = 1'b1;
  wire                    in_tready;
  wire                    out_tvalid;
  wire [OUT_TDATA_W-1:0]  out_tdata;

  int outstanding;
  int fail_count;
  int cycles     = 0;
  int stall_rate = 0;
  int gap_rate   = 0;
  int sink_hold  = 0;

  altimeter_moving_average_conditioner_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  amac_mean_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL altimeter_moving_average_conditioner_top");
      $finish;
    end
  end

  // Receiver drops out_tready at random and holds it low for a randomly drawn burst.
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold = sink_hold - 1;
      if (sink_hold == 0) out_tready <= 1'b1;
    end else if (stall_rate != 0 && $urandom_range(1, stall_rate) == 1) begin
      sink_hold = $urandom_range(1, 14);
      out_tready <= 1'b0;
    end
  end

  // Hold until every predicted result has been taken.
  task automatic wait_drained();
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_mode(input logic m);
    in_tvalid <= 1'b0;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_reading(input logic [7:0] msb, csb, lsb, tmsb, tlsb);
    if (gap_rate != 0 && $urandom_range(1, gap_rate) == 1) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {tlsb, tmsb, lsb, csb, msb};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [7:0] b [5];
    int         pause_at;
    logic       m;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    gap_rate   = 5;
    stall_rate <= 6;

    // Altitude: the first reading sets the start offset, warm-up zeros still count.
    set_mode(MODE_ALTITUDE);
    send_reading(8'h80, 8'h00, 8'h00, 8'h80, 8'h00);
    send_reading(8'h7F, 8'hFF, 8'hF0, 8'h7F, 8'hF0);
    send_reading(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_reading(8'h00, 8'h00, 8'h0F, 8'h00, 8'h0F);
    send_reading(8'h12, 8'h34, 8'h50, 8'h19, 8'h80);
    send_reading(8'h7F, 8'hFF, 8'hF0, 8'h7F, 8'hF0);
    send_reading(8'h7F, 8'hFF, 8'hF0, 8'h7F, 8'hF0);
    send_reading(8'h80, 8'h00, 8'h00, 8'h80, 8'h00);
    send_reading(8'h00, 8'h01, 8'h10, 8'hFE, 8'h40);
    send_reading(8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h96);

    // Pressure: old altitude entries stay in the window until overwritten.
    set_mode(MODE_PRESSURE);
    send_reading(8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hFF);
    send_reading(8'h00, 8'h00, 8'h00, 8'h80, 8'h00);
    send_reading(8'h00, 8'h00, 8'h30, 8'h00, 8'h00);
    send_reading(8'h00, 8'h00, 8'hC0, 8'h00, 8'h00);
    send_reading(8'h61, 8'hA8, 8'h40, 8'h16, 8'h80);
    send_reading(8'h62, 8'h70, 8'h80, 8'hE8, 8'h70);
    send_reading(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_reading(8'h5A, 8'hA5, 8'h3C, 8'h01, 8'h0F);

    foreach (b[i]) b[i] = pick_byte();
    for (int p = 0; p < PHASES; p++) begin
      m = (p % 2 == 0) ? MODE_ALTITUDE : MODE_PRESSURE;
      if (p == PHASES - 1) begin
        gap_rate   = 0;
        stall_rate <= 0;
      end else begin
        gap_rate   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 10);
        stall_rate <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 10);
      end
      set_mode(m);
      pause_at = $urandom_range(10, PHASE_ITEMS - 10);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == pause_at) begin
          in_tvalid <= 1'b0;
          wait_drained();
        end
        // repeat the last reading now and then so the mean settles
        if ($urandom_range(0, 3) != 0)
          foreach (b[k]) b[k] = pick_byte();
        send_reading(b[0], b[1], b[2], b[3], b[4]);
      end
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (12) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("PASS altimeter_moving_average_conditioner_top");
    else
      $display("FAIL altimeter_moving_average_conditioner_top");
    $finish;
  end

endmodule
